// File: design/hpp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpp_pkg
// Shared types, constants and effect tables of the haptic pattern player.
// ----------------------------------------------------------------------------
package hpp_pkg;

  localparam int NUM_EFFECTS = 14;
  localparam int MAX_STEPS   = 3;
  // catch-up bound of one tick
  localparam int GUARD_ITER  = 2 * 4 + 2;
  localparam int GUARD_W     = $clog2(GUARD_ITER + 1);

  localparam logic [2:0] PRIO_PLAY = 3'd2;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_PLAY   = 2'd1,
    OP_EFFECT = 2'd2,
    OP_STOP   = 2'd3
  } hpp_op_e;

  typedef enum logic [1:0] {
    CFG_ENABLED  = 2'd0,
    CFG_ON_LEVEL = 2'd1,
    CFG_RETRIGGER = 2'd2
  } hpp_cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIS,
    ST_OP,
    ST_ADV,
    ST_DONE
  } hpp_state_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] now_ms;
    logic [15:0] len_ms;
    logic [3:0]  effect;
  } hpp_in_t;

  typedef struct packed {
    logic       pin_level;
    logic       motor_on;
    logic       playing;
    logic       accepted;
    logic [2:0] current_priority;
  } hpp_out_t;

  typedef struct packed {
    logic load_item;
    logic finish_dis;
    logic exec_op;
    logic adv_step;
    logic load_out;
  } hpp_cmd_t;

  typedef struct packed {
    logic tick_pattern;
    logic adv_more;
  } hpp_stat_t;

  function automatic logic [15:0] fx_on(logic [3:0] e, logic [1:0] s);
    logic [15:0] v;
    v = 16'd0;
    case (e)
      4'd2, 4'd9: if (s == 2'd0) v = 16'd225;
      4'd10:      if (s == 2'd0) v = 16'd450;
      4'd11:      if (s inside {[2'd0:2'd1]}) v = 16'd400;
      4'd12:      if (s inside {[2'd0:2'd1]}) v = 16'd200;
      4'd13: begin
        if (s inside {[2'd0:2'd1]}) v = 16'd300;
        else if (s == 2'd2) v = 16'd800;
      end
      4'd14, 4'd15: v = 16'd0;
      default:    if (s == 2'd0) v = 16'd200;
    endcase
    return v;
  endfunction

  function automatic logic [15:0] fx_off(logic [3:0] e, logic [1:0] s);
    logic [15:0] v;
    v = 16'd0;
    case (e)
      4'd11:   if (s == 2'd0) v = 16'd200;
      4'd12:   if (s == 2'd0) v = 16'd250;
      4'd13:   if (s inside {[2'd0:2'd1]}) v = 16'd200;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

  function automatic logic [2:0] fx_length(logic [3:0] e);
    logic [2:0] n;
    case (e)
      4'd11, 4'd12: n = 3'd2;
      4'd13:        n = 3'd3;
      default:      n = 3'd1;
    endcase
    if (n > 3'(MAX_STEPS)) n = 3'(MAX_STEPS);
    return n;
  endfunction

  function automatic logic [2:0] fx_prio(logic [3:0] e);
    logic [2:0] p;
    case (e)
      4'd1, 4'd2, 4'd3, 4'd4, 4'd5: p = 3'd2;
      4'd6, 4'd7, 4'd8:             p = 3'd3;
      4'd9, 4'd10:                  p = 3'd4;
      4'd11, 4'd12, 4'd13:          p = 3'd5;
      default:                      p = 3'd1;
    endcase
    return p;
  endfunction

endpackage

// File: design/hpp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpp_ctrl
// Sequencer: takes a request, steps the datapath through disable check,
// opcode handling and effect catch-up, then hands the result to the output.
// ----------------------------------------------------------------------------
module hpp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  hpp_pkg::hpp_stat_t stat_i,
  output hpp_pkg::hpp_cmd_t  cmd_o
);
  import hpp_pkg::*;

  hpp_state_e         state_q, state_d;
  logic [GUARD_W-1:0] guard_q, guard_d;
  logic [GUARD_W-1:0] guard_inc;
  logic               out_valid_q, out_valid_d;

  assign guard_inc   = guard_q + 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      guard_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      guard_q     <= guard_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    guard_d     = guard_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = ST_DIS;
        end
      end
      ST_DIS: begin
        cmd_o.finish_dis = 1'b1;
        state_d          = ST_OP;
      end
      ST_OP: begin
        cmd_o.exec_op = 1'b1;
        guard_d       = '0;
        state_d       = stat_i.tick_pattern ? ST_ADV : ST_DONE;
      end
      ST_ADV: begin
        cmd_o.adv_step = 1'b1;
        guard_d        = guard_inc;
        if (!stat_i.adv_more || guard_inc >= GUARD_W'(GUARD_ITER)) state_d = ST_DONE;
      end
      ST_DONE: begin
        // output register free or being emptied this cycle
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  a_load_to_dis : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == ST_DIS)
    else $error("accepted request did not start processing");

  a_guard_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    guard_q <= GUARD_W'(GUARD_ITER))
    else $error("catch-up counter overran");

  a_adv_stop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ADV && !stat_i.adv_more |=> state_q == ST_DONE)
    else $error("catch-up kept going after the pattern settled");

  a_done_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |=> out_valid_q && state_q == ST_IDLE)
    else $error("result load did not raise out valid");

endmodule

// File: design/hpp_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpp_datapath
// Playback state, configuration registers, priority and cooldown check,
// one effect step transition per cycle, and the result register.
// ----------------------------------------------------------------------------
module hpp_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hpp_pkg::hpp_in_t   in_data_i,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  hpp_pkg::hpp_cmd_t  cmd_i,
  output hpp_pkg::hpp_stat_t stat_o,
  output hpp_pkg::hpp_out_t  out_data_o
);
  import hpp_pkg::*;

  hpp_in_t     item_q;
  hpp_out_t    out_q;

  logic        en_q, ah_q;
  logic [15:0] retrig_q;

  logic        active_q, active_d;
  logic        pattern_q, pattern_d;
  logic [3:0]  fx_idx_q, fx_idx_d;
  logic [1:0]  step_q, step_d;
  logic        gap_q, gap_d;
  logic [31:0] phase_q, phase_d;
  logic [15:0] dur_q, dur_d;
  logic [2:0]  prio_q, prio_d;
  logic        played_q, played_d;
  logic [31:0] last_q, last_d;
  logic        drive_q, drive_d;
  logic        acc_q, acc_d;

  logic [31:0] elapsed, since_last;
  logic [15:0] cur_on, cur_off;
  logic [1:0]  next_step;
  logic        step_end, wait_phase, cooling, fx_ok, req_ok, do_finish;
  logic [2:0]  req_prio;

  assign elapsed    = item_q.now_ms - phase_q;
  assign since_last = item_q.now_ms - last_q;
  assign cur_on     = fx_on(fx_idx_q, step_q);
  assign cur_off    = fx_off(fx_idx_q, step_q);
  assign next_step  = step_q + 2'd1;
  assign step_end   = (next_step == 2'd0) || ({1'b0, next_step} >= fx_length(fx_idx_q));
  assign wait_phase = gap_q ? (elapsed < {16'd0, cur_off}) : (elapsed < {16'd0, cur_on});

  assign fx_ok    = ({1'b0, item_q.effect} < 5'(NUM_EFFECTS));
  assign req_prio = (item_q.opcode == OP_PLAY) ? PRIO_PLAY : fx_prio(item_q.effect);
  assign cooling  = played_q && (since_last < {16'd0, retrig_q});
  assign req_ok   = en_q
                  && !(active_q && req_prio < prio_q)
                  && !(cooling && (!active_q || req_prio <= prio_q))
                  && ((item_q.opcode == OP_PLAY) || (item_q.opcode == OP_EFFECT && fx_ok));

  assign stat_o.tick_pattern = (item_q.opcode == OP_TICK) && active_q && pattern_q;
  assign stat_o.adv_more     = !wait_phase && ((!gap_q && cur_off != 16'd0) || !step_end);
  assign out_data_o          = out_q;

  always_comb begin
    active_d  = active_q;
    pattern_d = pattern_q;
    fx_idx_d  = fx_idx_q;
    step_d    = step_q;
    gap_d     = gap_q;
    phase_d   = phase_q;
    dur_d     = dur_q;
    prio_d    = prio_q;
    played_d  = played_q;
    last_d    = last_q;
    drive_d   = drive_q;
    acc_d     = acc_q;
    do_finish = 1'b0;

    if (cmd_i.load_item) acc_d = 1'b0;

    if (cmd_i.finish_dis && !en_q) do_finish = 1'b1;

    if (cmd_i.exec_op) begin
      case (item_q.opcode)
        OP_TICK: begin
          if (active_q && !pattern_q && elapsed >= {16'd0, dur_q}) do_finish = 1'b1;
        end
        OP_PLAY, OP_EFFECT: begin
          if (req_ok) begin
            acc_d    = 1'b1;
            played_d = 1'b1;
            last_d   = item_q.now_ms;
            prio_d   = req_prio;
            phase_d  = item_q.now_ms;
            active_d = 1'b1;
            step_d   = 2'd0;
            gap_d    = 1'b0;
            drive_d  = 1'b1;
            if (item_q.opcode == OP_PLAY) begin
              dur_d     = item_q.len_ms;
              pattern_d = 1'b0;
            end else begin
              dur_d     = fx_on(item_q.effect, 2'd0);
              pattern_d = 1'b1;
              fx_idx_d  = item_q.effect;
            end
          end
        end
        OP_STOP: do_finish = 1'b1;
        default: do_finish = 1'b1;
      endcase
    end

    if (cmd_i.adv_step && !wait_phase) begin
      if (!gap_q) begin
        drive_d = 1'b0;
        phase_d = phase_q + {16'd0, cur_on};
      end else begin
        phase_d = phase_q + {16'd0, cur_off};
      end
      if (!gap_q && cur_off != 16'd0) begin
        gap_d = 1'b1;
      end else begin
        // move on to the next step or end the effect
        step_d = next_step;
        if (step_end) begin
          do_finish = 1'b1;
        end else begin
          dur_d   = fx_on(fx_idx_q, next_step);
          gap_d   = 1'b0;
          drive_d = 1'b1;
        end
      end
    end

    if (do_finish) begin
      active_d  = 1'b0;
      prio_d    = 3'd0;
      pattern_d = 1'b0;
      step_d    = 2'd0;
      gap_d     = 1'b0;
      drive_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q      <= 1'b1;
      ah_q      <= 1'b1;
      retrig_q  <= 16'd50;
      active_q  <= 1'b0;
      pattern_q <= 1'b0;
      fx_idx_q  <= 4'd0;
      step_q    <= 2'd0;
      gap_q     <= 1'b0;
      phase_q   <= 32'd0;
      dur_q     <= 16'd0;
      prio_q    <= 3'd0;
      played_q  <= 1'b0;
      last_q    <= 32'd0;
      drive_q   <= 1'b0;
      acc_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ENABLED:   en_q     <= cfg_data_i[0];
          CFG_ON_LEVEL:  ah_q     <= cfg_data_i[0];
          CFG_RETRIGGER: retrig_q <= cfg_data_i;
          default: ;
        endcase
      end
      active_q  <= active_d;
      pattern_q <= pattern_d;
      fx_idx_q  <= fx_idx_d;
      step_q    <= step_d;
      gap_q     <= gap_d;
      phase_q   <= phase_d;
      dur_q     <= dur_d;
      prio_q    <= prio_d;
      played_q  <= played_d;
      last_q    <= last_d;
      drive_q   <= drive_d;
      acc_q     <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) item_q <= in_data_i;
    if (cmd_i.load_out) begin
      out_q.pin_level        <= drive_q ? ah_q : ~ah_q;
      out_q.motor_on         <= drive_q;
      out_q.playing          <= active_q;
      out_q.accepted         <= acc_q;
      out_q.current_priority <= prio_q;
    end
  end

  a_idle_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> prio_q == 3'd0 && !drive_q && !pattern_q)
    else $error("idle player holds priority or drive");

  a_prio_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    prio_q <= 3'd5)
    else $error("active priority out of range");

  a_accept_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec_op && req_ok && item_q.opcode != OP_TICK && item_q.opcode != OP_STOP
    |=> active_q && drive_q && acc_q && last_q == item_q.now_ms)
    else $error("accepted play did not start");

endmodule

// File: design/haptic_pattern_player.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// haptic_pattern_player
// Vibration motor pattern player: timed plays, ROM effects with priority
// and retrigger cooldown, one result per request.
// ----------------------------------------------------------------------------
// the result register loads after the disable check and opcode handling for
//   play, stop and timed ticks; an effect tick adds catch-up steps, one
//   on/off step transition per cycle, and a full output register holds the load
// requests: a new one is taken only in idle, after the last result is loaded
// reset: playback idle, motor off, enabled 1, on level high, retrigger 50 ms
module haptic_pattern_player (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  hpp_pkg::hpp_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output hpp_pkg::hpp_out_t out_data_o,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [15:0]      cfg_data_i
);
  import hpp_pkg::*;

  hpp_cmd_t  cmd;
  hpp_stat_t stat;

  hpp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  hpp_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_data_o (out_data_o)
  );

endmodule
